### rtl/obas_pkg.sv
// Shared constants, codes and control types for the order book arbitrage scan.
package obas_pkg;
    localparam int BOOK_LEVELS = 64;
    localparam int ADDR_W      = $clog2(BOOK_LEVELS);
    localparam int CNT_W       = $clog2(BOOK_LEVELS + 1);
    localparam int MAX_STEPS   = 63;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);
    localparam int Q_W         = 48;
    localparam int H_W         = Q_W / 2;
    localparam int FEE_W       = 16;
    localparam int PROF_W      = Q_W + 1;
    localparam int OP_W        = 2;
    localparam int REG_IDX_W   = 3;
    localparam int MSTEP_W     = 3;

    localparam logic [Q_W-1:0] Q_MAX     = {Q_W{1'b1}};
    localparam logic [H_W-1:0] H_MAX     = {H_W{1'b1}};
    localparam logic [Q_W-1:0] STEP_RST  = Q_W'(16777216);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_ASK     = 2'd1,
        OP_BID     = 2'd2,
        OP_SCAN    = 2'd3
    } t_op;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SELL_FEE  = 3'd0,
        REG_BUY_FEE   = 3'd1,
        REG_MIN_SIZE  = 3'd2,
        REG_MAX_SIZE  = 3'd3,
        REG_SIZE_STEP = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CHECK, S_WRD, S_WEV, S_CMP, S_MUL,
        S_FEE_S, S_FEE_B, S_FEE_SUM, S_PROF, S_EMIT, S_ADV, S_END
    } t_state;

    typedef struct packed {
        logic               acc_item;
        logic               scan_init;
        logic               walk_start;
        logic               walk_rd;
        logic               walk_ev;
        logic               mul_en;
        logic [MSTEP_W-1:0] mul_step;
        logic               fee_s;
        logic               fee_b;
        logic               fee_sum;
        logic               prof;
        logic               adv;
        logic               emit_var;
        logic               emit_end;
    } t_cmd;

    typedef struct packed {
        logic size_gt_max;
        logic totals_ok;
        logic walk_done;
        logic rate_gt;
        logic step_ovf;
        logic out_free;
    } t_stat;
endpackage

### rtl/obas_in_if.sv
// Input channel: book commands and level data.
interface obas_in_if;
    import obas_pkg::*;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] opcode;
    logic [Q_W-1:0]  level_rate;
    logic [Q_W-1:0]  level_amount;
    modport source (output valid, output opcode, output level_rate,
                    output level_amount, input ready);
    modport sink   (input valid, input opcode, input level_rate,
                    input level_amount, output ready);
endinterface

### rtl/obas_out_if.sv
// Output channel: scan variants and end marker.
interface obas_out_if;
    import obas_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     variant_valid;
    logic [Q_W-1:0]           order_size;
    logic [Q_W-1:0]           deep_bid_rate;
    logic [Q_W-1:0]           deep_ask_rate;
    logic [Q_W-1:0]           total_fee;
    logic signed [PROF_W-1:0] profit;
    logic                     profitable;
    logic                     book_overflow;
    logic                     last;
    modport source (output valid, output variant_valid, output order_size,
                    output deep_bid_rate, output deep_ask_rate, output total_fee,
                    output profit, output profitable, output book_overflow,
                    output last, input ready);
    modport sink   (input valid, input variant_valid, input order_size,
                    input deep_bid_rate, input deep_ask_rate, input total_fee,
                    input profit, input profitable, input book_overflow,
                    input last, output ready);
endinterface

### rtl/order_book_arbitrage_scan.sv
// Top level of the order book arbitrage scan: sequencer plus datapath.
//
// Loads an ask and a bid book (up to 64 levels each, best price first) and
// scans order sizes from min_size to max_size in size_step increments, at
// most 63 sizes. Clear and append commands can arrive back to back. A
// scan holds the input channel until its end marker has been loaded into
// the output register. Each scanned size runs the bound checks, then walks
// both books side by side, one memory read and one evaluate step per
// level, up to depth+1 steps; a size whose deep bid rate exceeds its deep
// ask rate then takes eight passes through one shared 24x24 multiplier for
// the two Q24.24 prices, then two fee products, the fee sum, the profit
// and the output load. Every result goes through a single output register,
// so a stalled sink stalls the scan. The book memories need no clearing
// pass; levels beyond the fill count may be read but are never used.
module order_book_arbitrage_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [obas_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [obas_pkg::Q_W-1:0]       i_cfg_data,
    obas_in_if.sink                        i_in,
    obas_out_if.source                     o_out
);
    import obas_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    obas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    obas_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_in.opcode),
        .i_level_rate   (i_in.level_rate),
        .i_level_amount (i_in.level_amount),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out          (o_out)
    );
endmodule

### rtl/obas_ctrl.sv
// Scan sequencer: state machine, scan step counter and multiply step counter.
module obas_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [obas_pkg::OP_W-1:0] i_opcode,
    input  obas_pkg::t_stat       i_stat,
    output obas_pkg::t_cmd        o_cmd,
    output logic                  o_in_ready
);
    import obas_pkg::*;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_steps;
    logic [MSTEP_W-1:0] r_mstep;
    logic               w_steps_done;

    assign w_steps_done = (r_steps == STEP_W'(MAX_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_steps <= '0;
            r_mstep <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) r_steps <= '0;
            else if (r_state == S_ADV && !i_stat.step_ovf) r_steps <= r_steps + 1'b1;
            if (r_state == S_CMP) r_mstep <= '0;
            else if (r_state == S_MUL) r_mstep <= r_mstep + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && t_op'(i_opcode) == OP_SCAN) n_state = S_INIT;
            end
            S_INIT:  n_state = S_CHECK;
            S_CHECK: begin
                if (w_steps_done || i_stat.size_gt_max) n_state = S_END;
                else if (i_stat.totals_ok) n_state = S_WRD;
                else n_state = S_ADV;
            end
            S_WRD:     n_state = i_stat.walk_done ? S_CMP : S_WEV;
            S_WEV:     n_state = S_WRD;
            S_CMP:     n_state = i_stat.rate_gt ? S_MUL : S_ADV;
            S_MUL:     n_state = (r_mstep == {MSTEP_W{1'b1}}) ? S_FEE_S : S_MUL;
            S_FEE_S:   n_state = S_FEE_B;
            S_FEE_B:   n_state = S_FEE_SUM;
            S_FEE_SUM: n_state = S_PROF;
            S_PROF:    n_state = S_EMIT;
            S_EMIT:    n_state = i_stat.out_free ? S_ADV : S_EMIT;
            S_ADV:     n_state = i_stat.step_ovf ? S_END : S_CHECK;
            S_END:     n_state = i_stat.out_free ? S_IDLE : S_END;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.mul_step = r_mstep;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.acc_item = i_in_valid;
            end
            S_INIT:    o_cmd.scan_init  = 1'b1;
            S_CHECK:   o_cmd.walk_start = !w_steps_done && !i_stat.size_gt_max
                                          && i_stat.totals_ok;
            S_WRD:     o_cmd.walk_rd    = !i_stat.walk_done;
            S_WEV:     o_cmd.walk_ev    = 1'b1;
            S_MUL:     o_cmd.mul_en     = 1'b1;
            S_FEE_S:   o_cmd.fee_s      = 1'b1;
            S_FEE_B:   o_cmd.fee_b      = 1'b1;
            S_FEE_SUM: o_cmd.fee_sum    = 1'b1;
            S_PROF:    o_cmd.prof       = 1'b1;
            S_EMIT:    o_cmd.emit_var   = i_stat.out_free;
            S_ADV:     o_cmd.adv        = !i_stat.step_ovf;
            S_END:     o_cmd.emit_end   = i_stat.out_free;
            S_CMP: ;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_var || o_cmd.emit_end) |-> i_stat.out_free)
        else $error("emit while output busy");
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) |-> !w_steps_done)
        else $error("scan step count overrun");
`endif
endmodule

### rtl/obas_dp.sv
// Datapath: book memories, depth walkers, Q24.24 multiply, fees, output register.
module obas_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [obas_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [obas_pkg::Q_W-1:0]     i_cfg_data,
    input  logic [obas_pkg::OP_W-1:0]    i_opcode,
    input  logic [obas_pkg::Q_W-1:0]     i_level_rate,
    input  logic [obas_pkg::Q_W-1:0]     i_level_amount,
    input  obas_pkg::t_cmd               i_cmd,
    output obas_pkg::t_stat              o_stat,
    obas_out_if.source                   o_out
);
    import obas_pkg::*;

    // configuration
    logic [FEE_W-1:0] r_sell_fee, r_buy_fee;
    logic [Q_W-1:0]   r_min_size, r_max_size, r_size_step;

    // books
    logic [2*Q_W-1:0] ask_mem [BOOK_LEVELS];
    logic [2*Q_W-1:0] bid_mem [BOOK_LEVELS];
    logic [2*Q_W-1:0] r_ask_rd, r_bid_rd;
    logic [CNT_W-1:0] r_ask_cnt, r_bid_cnt;
    logic [Q_W-1:0]   r_ask_tot, r_bid_tot;
    logic             r_ovf;

    // walkers
    logic [CNT_W-1:0] r_ask_idx, r_bid_idx;
    logic [Q_W-1:0]   r_ask_fill, r_bid_fill, r_ask_rate, r_bid_rate;
    logic             r_ask_done, r_bid_done;

    // scan arithmetic
    logic [Q_W-1:0]     r_size;
    logic [Q_W+1:0]     r_acc;
    logic [Q_W-1:0]     r_sp, r_bp, r_fs, r_fb, r_fee;
    logic signed [PROF_W-1:0] r_prof;

    // output register
    logic r_ov;
    logic r_vv, r_pf, r_bo, r_last;
    logic [Q_W-1:0] r_o_size, r_o_sr, r_o_br, r_o_fee;
    logic signed [PROF_W-1:0] r_o_prof;

    logic [Q_W:0]   w_ask_sum, w_bid_sum;
    logic [Q_W-1:0] w_ask_left, w_bid_left, w_ask_amt, w_bid_amt;
    logic [Q_W-1:0] w_mb;
    logic [H_W-1:0] w_ma, w_mbh;
    logic [Q_W-1:0] w_prod;
    logic [Q_W+2:0] w_final;
    logic [Q_W-1:0] w_qres;
    logic [Q_W+FEE_W-1:0] w_fs_prod, w_fb_prod;
    logic [Q_W:0]   w_fee_sum;
    logic signed [Q_W+1:0] w_p;
    logic           w_push_ask, w_push_bid;

    assign w_push_ask = i_cmd.acc_item && t_op'(i_opcode) == OP_ASK;
    assign w_push_bid = i_cmd.acc_item && t_op'(i_opcode) == OP_BID;
    assign w_ask_sum  = {1'b0, r_ask_tot} + {1'b0, i_level_amount};
    assign w_bid_sum  = {1'b0, r_bid_tot} + {1'b0, i_level_amount};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sell_fee  <= '0;
            r_buy_fee   <= '0;
            r_min_size  <= '0;
            r_max_size  <= '0;
            r_size_step <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SELL_FEE:  r_sell_fee  <= i_cfg_data[FEE_W-1:0];
                REG_BUY_FEE:   r_buy_fee   <= i_cfg_data[FEE_W-1:0];
                REG_MIN_SIZE:  r_min_size  <= i_cfg_data;
                REG_MAX_SIZE:  r_max_size  <= i_cfg_data;
                REG_SIZE_STEP: r_size_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // book memories
    always_ff @(posedge i_clk) begin
        if (w_push_ask && r_ask_cnt < CNT_W'(BOOK_LEVELS))
            ask_mem[r_ask_cnt[ADDR_W-1:0]] <= {i_level_rate, i_level_amount};
        if (w_push_bid && r_bid_cnt < CNT_W'(BOOK_LEVELS))
            bid_mem[r_bid_cnt[ADDR_W-1:0]] <= {i_level_rate, i_level_amount};
        if (i_cmd.walk_rd) begin
            r_ask_rd <= ask_mem[r_ask_idx[ADDR_W-1:0]];
            r_bid_rd <= bid_mem[r_bid_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ask_cnt <= '0;
            r_bid_cnt <= '0;
            r_ask_tot <= '0;
            r_bid_tot <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.acc_item) begin
            unique case (t_op'(i_opcode))
                OP_CLEAR: begin
                    r_ask_cnt <= '0;
                    r_bid_cnt <= '0;
                    r_ask_tot <= '0;
                    r_bid_tot <= '0;
                    r_ovf     <= 1'b0;
                end
                OP_ASK: begin
                    if (r_ask_cnt >= CNT_W'(BOOK_LEVELS)) r_ovf <= 1'b1;
                    else begin
                        r_ask_cnt <= r_ask_cnt + 1'b1;
                        r_ask_tot <= w_ask_sum[Q_W] ? Q_MAX : w_ask_sum[Q_W-1:0];
                    end
                end
                OP_BID: begin
                    if (r_bid_cnt >= CNT_W'(BOOK_LEVELS)) r_ovf <= 1'b1;
                    else begin
                        r_bid_cnt <= r_bid_cnt + 1'b1;
                        r_bid_tot <= w_bid_sum[Q_W] ? Q_MAX : w_bid_sum[Q_W-1:0];
                    end
                end
                OP_SCAN: ;
                default: ;
            endcase
        end
    end

    // depth walkers, one level per read/evaluate pair
    assign w_ask_left = r_size - r_ask_fill;
    assign w_bid_left = r_size - r_bid_fill;
    assign w_ask_amt  = r_ask_rd[Q_W-1:0];
    assign w_bid_amt  = r_bid_rd[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ask_idx  <= '0;
            r_bid_idx  <= '0;
            r_ask_fill <= '0;
            r_bid_fill <= '0;
            r_ask_rate <= '0;
            r_bid_rate <= '0;
            r_ask_done <= 1'b1;
            r_bid_done <= 1'b1;
        end else if (i_cmd.walk_start) begin
            r_ask_idx  <= '0;
            r_bid_idx  <= '0;
            r_ask_fill <= '0;
            r_bid_fill <= '0;
            r_ask_rate <= '0;
            r_bid_rate <= '0;
            r_ask_done <= 1'b0;
            r_bid_done <= 1'b0;
        end else if (i_cmd.walk_ev) begin
            if (!r_ask_done) begin
                if (r_ask_idx >= r_ask_cnt || r_ask_fill >= r_size) r_ask_done <= 1'b1;
                else begin
                    r_ask_fill <= r_ask_fill + ((w_ask_left > w_ask_amt) ? w_ask_amt
                                                                         : w_ask_left);
                    r_ask_rate <= r_ask_rd[2*Q_W-1:Q_W];
                    r_ask_idx  <= r_ask_idx + 1'b1;
                end
            end
            if (!r_bid_done) begin
                if (r_bid_idx >= r_bid_cnt || r_bid_fill >= r_size) r_bid_done <= 1'b1;
                else begin
                    r_bid_fill <= r_bid_fill + ((w_bid_left > w_bid_amt) ? w_bid_amt
                                                                         : w_bid_left);
                    r_bid_rate <= r_bid_rd[2*Q_W-1:Q_W];
                    r_bid_idx  <= r_bid_idx + 1'b1;
                end
            end
        end
    end

    // shared 24x24 multiplier; steps 0-3 size*sell rate, 4-7 size*buy rate
    assign w_mb   = i_cmd.mul_step[2] ? r_ask_rate : r_bid_rate;
    assign w_ma   = i_cmd.mul_step[1] ? r_size[Q_W-1:H_W] : r_size[H_W-1:0];
    assign w_mbh  = i_cmd.mul_step[0] ? w_mb[Q_W-1:H_W] : w_mb[H_W-1:0];
    assign w_prod = {{H_W{1'b0}}, w_ma} * {{H_W{1'b0}}, w_mbh};
    assign w_final = {3'b0, r_acc[Q_W-1:0]} + {1'b0, r_acc[Q_W+1:Q_W], {Q_W{1'b0}}}
                     + {3'b0, w_prod[H_W-1:0], {H_W{1'b0}}};
    assign w_qres = (w_prod > {{H_W{1'b0}}, H_MAX} || w_final > {3'b0, Q_MAX})
                    ? Q_MAX : w_final[Q_W-1:0];

    assign w_fs_prod = r_sp * r_sell_fee;
    assign w_fb_prod = r_bp * r_buy_fee;
    assign w_fee_sum = {1'b0, r_fs} + {1'b0, r_fb};
    assign w_p = $signed({2'b0, r_sp}) - $signed({2'b0, r_bp}) - $signed({2'b0, r_fee});

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) r_size <= r_min_size;
        else if (i_cmd.adv)  r_size <= r_size + r_size_step;
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_step[1:0])
                2'd0: r_acc <= {{(H_W+2){1'b0}}, w_prod[Q_W-1:H_W]};
                2'd1, 2'd2: r_acc <= r_acc + {2'b0, w_prod};
                2'd3: begin
                    if (i_cmd.mul_step[2]) r_bp <= w_qres;
                    else r_sp <= w_qres;
                end
                default: ;
            endcase
        end
        if (i_cmd.fee_s)   r_fs  <= w_fs_prod[Q_W+FEE_W-1:FEE_W];
        if (i_cmd.fee_b)   r_fb  <= w_fb_prod[Q_W+FEE_W-1:FEE_W];
        if (i_cmd.fee_sum) r_fee <= w_fee_sum[Q_W] ? Q_MAX : w_fee_sum[Q_W-1:0];
        if (i_cmd.prof) begin
            if (w_p < -$signed({2'b01, {Q_W{1'b0}}})) r_prof <= {1'b1, {Q_W{1'b0}}};
            else r_prof <= w_p[PROF_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_cmd.emit_var || i_cmd.emit_end) r_ov <= 1'b1;
        else if (o_out.ready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_var) begin
            r_vv     <= 1'b1;
            r_o_size <= r_size;
            r_o_sr   <= r_bid_rate;
            r_o_br   <= r_ask_rate;
            r_o_fee  <= r_fee;
            r_o_prof <= r_prof;
            r_pf     <= !r_prof[PROF_W-1] && (r_prof != '0);
            r_bo     <= r_ovf;
            r_last   <= 1'b0;
        end else if (i_cmd.emit_end) begin
            r_vv     <= 1'b0;
            r_o_size <= '0;
            r_o_sr   <= '0;
            r_o_br   <= '0;
            r_o_fee  <= '0;
            r_o_prof <= '0;
            r_pf     <= 1'b0;
            r_bo     <= r_ovf;
            r_last   <= 1'b1;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.variant_valid = r_vv;
    assign o_out.order_size    = r_o_size;
    assign o_out.deep_bid_rate = r_o_sr;
    assign o_out.deep_ask_rate = r_o_br;
    assign o_out.total_fee     = r_o_fee;
    assign o_out.profit        = r_o_prof;
    assign o_out.profitable    = r_pf;
    assign o_out.book_overflow = r_bo;
    assign o_out.last          = r_last;

    assign o_stat.size_gt_max = r_size > r_max_size;
    assign o_stat.totals_ok   = (r_ask_tot >= r_size) && (r_bid_tot >= r_size);
    assign o_stat.walk_done   = r_ask_done && r_bid_done;
    assign o_stat.rate_gt     = r_bid_rate > r_ask_rate;
    assign o_stat.step_ovf    = r_size_step > (Q_MAX - r_size);
    assign o_stat.out_free    = !r_ov || o_out.ready;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ask_cnt <= CNT_W'(BOOK_LEVELS)) && (r_bid_cnt <= CNT_W'(BOOK_LEVELS)))
        else $error("book count beyond depth");
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_end |=> (r_ov && r_last && !r_vv))
        else $error("end marker not presented");
    a_walk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ask_done && !i_cmd.walk_start) |=> $stable(r_ask_rate))
        else $error("finished walk changed its rate");
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ask_done |-> (r_ask_idx <= r_ask_cnt))
        else $error("walk index past book end");
`endif
endmodule

### dv/tb_order_book_arbitrage_scan.sv
// Self-checking testbench for the order book arbitrage scan block.
`timescale 1ns / 1ps

module tb_order_book_arbitrage_scan;
    import obas_pkg::*;

    // One scan result as seen on the output channel.
    typedef struct packed {
        logic                     variant_valid;
        logic [Q_W-1:0]           order_size;
        logic [Q_W-1:0]           deep_bid_rate;
        logic [Q_W-1:0]           deep_ask_rate;
        logic [Q_W-1:0]           total_fee;
        logic signed [PROF_W-1:0] profit;
        logic                     profitable;
        logic                     book_overflow;
        logic                     last;
    } t_scan_result;

    // Book model plus the queue of scan results still owed by the block.
    class t_arb_scoreboard;
        logic [Q_W-1:0]   ask_rate_m [BOOK_LEVELS];
        logic [Q_W-1:0]   ask_amt_m  [BOOK_LEVELS];
        logic [Q_W-1:0]   bid_rate_m [BOOK_LEVELS];
        logic [Q_W-1:0]   bid_amt_m  [BOOK_LEVELS];
        int               ask_n, bid_n;
        logic [Q_W-1:0]   ask_sum, bid_sum;
        logic             dropped;
        logic [FEE_W-1:0] fee_sell, fee_buy;
        logic [Q_W-1:0]   size_lo, size_hi, size_inc;
        t_scan_result     owed_q[$];
        int               errors;

        function new();
            ask_n    = 0;
            bid_n    = 0;
            ask_sum  = '0;
            bid_sum  = '0;
            dropped  = 1'b0;
            fee_sell = '0;
            fee_buy  = '0;
            size_lo  = '0;
            size_hi  = '0;
            size_inc = STEP_RST;
            errors   = 0;
        endfunction

        function void write_reg(t_reg idx, logic [Q_W-1:0] val);
            case (idx)
                REG_SELL_FEE:  fee_sell = val[FEE_W-1:0];
                REG_BUY_FEE:   fee_buy  = val[FEE_W-1:0];
                REG_MIN_SIZE:  size_lo  = val;
                REG_MAX_SIZE:  size_hi  = val;
                REG_SIZE_STEP: size_inc = val;
                default: ;
            endcase
        endfunction

        function logic [Q_W-1:0] sat_add(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
            logic [Q_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[Q_W] ? Q_MAX : s[Q_W-1:0];
        endfunction

        function logic [Q_W-1:0] price_of(logic [Q_W-1:0] a, logic [Q_W-1:0] b);
            logic [2*Q_W-1:0] p;
            p = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b};
            p = p >> H_W;
            return (p > {{Q_W{1'b0}}, Q_MAX}) ? Q_MAX : p[Q_W-1:0];
        endfunction

        // Rate of the deepest level touched when filling sz.
        function logic [Q_W-1:0] deepest_rate(bit is_ask, logic [Q_W-1:0] sz);
            logic [Q_W-1:0] rate, filled, left, amt;
            int n;
            rate   = '0;
            filled = '0;
            n      = is_ask ? ask_n : bid_n;
            for (int i = 0; i < n; i++) begin
                if (filled >= sz) break;
                amt    = is_ask ? ask_amt_m[i] : bid_amt_m[i];
                left   = sz - filled;
                filled = filled + ((left > amt) ? amt : left);
                rate   = is_ask ? ask_rate_m[i] : bid_rate_m[i];
            end
            return rate;
        endfunction

        function void run_scan();
            logic [Q_W-1:0]     sz, br, sr, sp, bp, fee;
            logic [63:0]        fs, fb, fsum;
            logic signed [63:0] pr;
            t_scan_result       r;
            sz = size_lo;
            for (int st = 0; st < MAX_STEPS; st++) begin
                if (sz > size_hi) break;
                if (ask_sum >= sz && bid_sum >= sz) begin
                    br = deepest_rate(1'b1, sz);
                    sr = deepest_rate(1'b0, sz);
                    if (sr > br) begin
                        sp   = price_of(sz, sr);
                        bp   = price_of(sz, br);
                        fs   = ({16'b0, sp} * {48'b0, fee_sell}) >> FEE_W;
                        fb   = ({16'b0, bp} * {48'b0, fee_buy}) >> FEE_W;
                        fsum = fs + fb;
                        fee  = (fsum > {16'b0, Q_MAX}) ? Q_MAX : fsum[Q_W-1:0];
                        pr   = $signed({16'b0, sp}) - $signed({16'b0, bp})
                               - $signed({16'b0, fee});
                        if (pr > $signed({16'b0, Q_MAX})) pr = $signed({16'b0, Q_MAX});
                        if (pr < -$signed({16'b0, Q_MAX}) - 1)
                            pr = -$signed({16'b0, Q_MAX}) - 1;
                        r.variant_valid = 1'b1;
                        r.order_size    = sz;
                        r.deep_bid_rate = sr;
                        r.deep_ask_rate = br;
                        r.total_fee     = fee;
                        r.profit        = pr[PROF_W-1:0];
                        r.profitable    = (pr > 0);
                        r.book_overflow = dropped;
                        r.last          = 1'b0;
                        owed_q.insert(owed_q.size(), r);
                    end
                end
                if (size_inc > Q_MAX - sz) break;
                sz = sz + size_inc;
            end
            r = '{default: '0};
            r.book_overflow = dropped;
            r.last          = 1'b1;
            owed_q.insert(owed_q.size(), r);
        endfunction

        // Called on every accepted command transfer.
        function void note_command(t_op op, logic [Q_W-1:0] rate, logic [Q_W-1:0] amt);
            case (op)
                OP_CLEAR: begin
                    ask_n   = 0;
                    bid_n   = 0;
                    ask_sum = '0;
                    bid_sum = '0;
                    dropped = 1'b0;
                end
                OP_ASK: begin
                    if (ask_n >= BOOK_LEVELS) dropped = 1'b1;
                    else begin
                        ask_rate_m[ask_n] = rate;
                        ask_amt_m[ask_n]  = amt;
                        ask_n++;
                        ask_sum = sat_add(ask_sum, amt);
                    end
                end
                OP_BID: begin
                    if (bid_n >= BOOK_LEVELS) dropped = 1'b1;
                    else begin
                        bid_rate_m[bid_n] = rate;
                        bid_amt_m[bid_n]  = amt;
                        bid_n++;
                        bid_sum = sat_add(bid_sum, amt);
                    end
                end
                default: run_scan();
            endcase
        endfunction

        function void check_result(t_scan_result got);
            t_scan_result want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result: got %p", $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got !== want) begin
                $display("%0t: result mismatch: expected %p", $time, want);
                $display("%0t:                  actual   %p", $time, got);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [Q_W-1:0]     i_cfg_data;

    obas_in_if  cmd_ch ();
    obas_out_if res_ch ();

    order_book_arbitrage_scan uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cmd_ch),
        .o_out      (res_ch)
    );

    t_arb_scoreboard sb = new();
    int send_idle_pct  = 0;   // percent of cycles the sender holds off
    int stall_pct      = 0;   // percent of cycles the receiver stalls

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: ready changes only on the falling edge.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Output monitor: every transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin
        t_scan_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.variant_valid = res_ch.variant_valid;
            got.order_size    = res_ch.order_size;
            got.deep_bid_rate = res_ch.deep_bid_rate;
            got.deep_ask_rate = res_ch.deep_ask_rate;
            got.total_fee     = res_ch.total_fee;
            got.profit        = res_ch.profit;
            got.profitable    = res_ch.profitable;
            got.book_overflow = res_ch.book_overflow;
            got.last          = res_ch.last;
            sb.check_result(got);
        end
    end

    function automatic logic [Q_W-1:0] rand48();
        return Q_W'({$urandom(), $urandom()});
    endfunction

    // Q24.24 value with integer part ip and a random fraction.
    function automatic logic [Q_W-1:0] fixq(int ip);
        return {ip[H_W-1:0], 24'($urandom())};
    endfunction

    // Drive one command and hold it until the block takes it.
    task automatic send_cmd(t_op op, logic [Q_W-1:0] rate, logic [Q_W-1:0] amt);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= op;
        cmd_ch.level_rate   <= rate;
        cmd_ch.level_amount <= amt;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = cmd_ch.ready;
            @(negedge i_clk);
        end
        sb.note_command(op, rate, amt);
    endtask

    // Config writes happen only with nothing in flight; appends leave no
    // result behind, so settle also lets the clock run on after the queue drains.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Write enable stays high; the caller drops it after the last write.
    task automatic write_reg(t_reg idx, logic [Q_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_scan(logic [FEE_W-1:0] fs, logic [FEE_W-1:0] fb,
                            logic [Q_W-1:0] lo, logic [Q_W-1:0] hi,
                            logic [Q_W-1:0] inc);
        settle();
        write_reg(REG_SELL_FEE, Q_W'(fs));
        write_reg(REG_BUY_FEE, Q_W'(fb));
        write_reg(REG_MIN_SIZE, lo);
        write_reg(REG_MAX_SIZE, hi);
        write_reg(REG_SIZE_STEP, inc);
        i_cfg_we <= 1'b0;
    endtask

    // Clear, load n_ask asks rising and n_bid bids falling, then scan.
    // Returns the number of commands sent.
    task automatic book_and_scan(int n_ask, int n_bid, output int sent);
        int ask_base, bid_base;
        ask_base = $urandom_range(1, 40);
        bid_base = ask_base + $urandom_range(0, 30);
        send_cmd(OP_CLEAR, rand48(), rand48());
        for (int i = 0; i < n_ask; i++)
            send_cmd(OP_ASK, fixq(ask_base + i), fixq($urandom_range(0, 6)));
        for (int i = 0; i < n_bid; i++)
            send_cmd(OP_BID, fixq(bid_base > i ? bid_base - i : 0),
                     fixq($urandom_range(0, 6)));
        send_cmd(OP_SCAN, rand48(), rand48());
        sent = n_ask + n_bid + 2;
    endtask

    initial begin
        int sent, cnt, n;
        logic [Q_W-1:0] lo, inc;
        cmd_ch.valid        = 1'b0;
        cmd_ch.opcode       = OP_CLEAR;
        cmd_ch.level_rate   = '0;
        cmd_ch.level_amount = '0;
        res_ch.ready        = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = REG_SELL_FEE;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty-book scan at reset settings, saturating totals,
        // full-scale rates, zero amount, zero step, min above max, clear.
        send_cmd(OP_SCAN, '0, '0);
        send_cmd(OP_ASK, fixq(1), Q_MAX);
        send_cmd(OP_ASK, Q_MAX, Q_W'(5));
        send_cmd(OP_BID, Q_MAX, Q_MAX);
        send_cmd(OP_BID, fixq(2), '0);
        set_scan(16'hFFFF, 16'hFFFF, fixq(1), fixq(3), STEP_RST);
        send_cmd(OP_SCAN, Q_MAX, Q_MAX);
        set_scan(16'h0000, 16'h0000, Q_MAX, Q_MAX, '0);
        send_cmd(OP_SCAN, '0, '0);
        set_scan(16'h8000, 16'h0001, '0, Q_MAX, Q_MAX);
        send_cmd(OP_SCAN, '0, '0);
        set_scan(16'h1234, 16'h4321, fixq(5), fixq(2), STEP_RST);
        send_cmd(OP_SCAN, '0, '0);
        send_cmd(OP_CLEAR, Q_MAX, Q_MAX);
        send_cmd(OP_SCAN, '0, '0);

        // Random: four idling modes, two settings each.
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            lo  = fixq($urandom_range(0, 3));
            inc = {24'($urandom_range(0, 2)), 24'($urandom())};
            case (ph)
                0: set_scan(16'h0000, 16'h0000, lo, lo + 10 * inc, inc);
                3: set_scan(16'hFFFF, 16'hFFFF, lo, Q_MAX, inc);
                5: set_scan(16'($urandom()), 16'($urandom()), lo, lo, '0);
                default: set_scan(16'($urandom()), 16'($urandom()), lo,
                                  lo + $urandom_range(0, 12) * inc, inc);
            endcase
            cnt = 0;
            while (cnt < 15) begin
                if (!(ph == 4 && cnt == 0) && $urandom_range(0, 5) == 0) begin
                    // noise: any command with full-range fields
                    send_cmd(t_op'($urandom_range(0, 3)), rand48(), rand48());
                    cnt++;
                end else begin
                    n = $urandom_range(1, 6);
                    if (ph == 4 && cnt == 0)
                        book_and_scan(BOOK_LEVELS + 1, n, sent);  // force overflow
                    else
                        book_and_scan(n, n, sent);
                    cnt += sent;
                end
            end
        end

        settle();
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
rtl/obas_pkg.sv
rtl/obas_in_if.sv
rtl/obas_out_if.sv
rtl/obas_ctrl.sv
rtl/obas_dp.sv
rtl/order_book_arbitrage_scan.sv
dv/tb_order_book_arbitrage_scan.sv
